// File: rtl/c3mn_pkg.sv
// Shared types, constants and register codes of the 3x3 mirror-padded convolution block.
package c3mn_pkg;

    // Fixed geometry and number formats.
    localparam int unsigned KERNEL_SIZE     = 3;
    localparam int unsigned PIX_BITS        = 8;
    localparam int unsigned RGB_BITS        = 3 * PIX_BITS;
    localparam int unsigned MAX_HEIGHT      = 4096;
    localparam int unsigned SCALE_FRAC      = 16;
    localparam int unsigned DEF_MAX_WIDTH   = 1024;
    localparam int unsigned DEF_COEF_BITS   = 16;

    // Configuration register widths.
    localparam int unsigned FW_BITS   = 11;
    localparam int unsigned FH_BITS   = 13;
    localparam int unsigned MASK_BITS = 48;
    localparam int unsigned NORM_BITS = 24;
    localparam int unsigned IDX_BITS  = 3;

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_BITS-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_BITS-1:0] CFG_MASK_TOP     = 3'd2;
    localparam logic [IDX_BITS-1:0] CFG_MASK_MID     = 3'd3;
    localparam logic [IDX_BITS-1:0] CFG_MASK_BOTTOM  = 3'd4;
    localparam logic [IDX_BITS-1:0] CFG_NORM_SCALE   = 3'd5;
    localparam logic [IDX_BITS-1:0] CFG_CLAMP        = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [FW_BITS-1:0]   RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_BITS-1:0]   RST_FRAME_HEIGHT = 13'd480;
    localparam logic [MASK_BITS-1:0] RST_MASK_TOP     = 48'd0;
    localparam logic [MASK_BITS-1:0] RST_MASK_MID     = 48'd256;
    localparam logic [MASK_BITS-1:0] RST_MASK_BOTTOM  = 48'd0;
    localparam logic [NORM_BITS-1:0] RST_NORM_SCALE   = 24'd65536;

    // Output field widths.
    localparam int unsigned RES_BITS = 16;
    localparam int unsigned COL_BITS = 10;
    localparam int unsigned ROW_BITS = 12;

    typedef struct packed {
        logic [PIX_BITS-1:0] pix_red;
        logic [PIX_BITS-1:0] pix_green;
        logic [PIX_BITS-1:0] pix_blue;
        logic                is_drain;
    } t_in_item;

    typedef struct packed {
        logic signed [RES_BITS-1:0] res_red;
        logic signed [RES_BITS-1:0] res_green;
        logic signed [RES_BITS-1:0] res_blue;
        logic [COL_BITS-1:0]        res_col;
        logic [ROW_BITS-1:0]        res_row;
        logic                       frame_done;
    } t_out_item;

    // Window of pixels, indexed [column][row], each entry {blue, green, red}.
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][RGB_BITS-1:0] t_window;

    // Start request to the filter unit with the mirrored tap selection.
    typedef struct packed {
        logic                             start;
        logic [KERNEL_SIZE-1:0][1:0]      csel;
        logic [KERNEL_SIZE-1:0][1:0]      rsel;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_sts;

endpackage

// File: rtl/c3mn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module c3mn_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/c3mn_mac.sv
// Shared multiply-accumulate unit: filters the window one tap a cycle, then scales and limits.
module c3mn_mac #(
    parameter int unsigned COEF_BITS = c3mn_pkg::DEF_COEF_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  c3mn_pkg::t_mac_ctl                 i_ctl,
    input  c3mn_pkg::t_window                  i_win,
    input  logic [c3mn_pkg::MASK_BITS-1:0]     i_mask_top,
    input  logic [c3mn_pkg::MASK_BITS-1:0]     i_mask_mid,
    input  logic [c3mn_pkg::MASK_BITS-1:0]     i_mask_bottom,
    input  logic [c3mn_pkg::NORM_BITS-1:0]     i_scale,
    input  logic                               i_clamp,
    output c3mn_pkg::t_mac_sts                 o_sts,
    output logic [2:0][c3mn_pkg::RES_BITS-1:0] o_res
);

    localparam int unsigned ACC_W = COEF_BITS + 12;
    localparam int unsigned TAP_W = COEF_BITS + 9;
    localparam int unsigned PW    = ACC_W + c3mn_pkg::NORM_BITS + 1;
    localparam int unsigned SHIFT = COEF_BITS / 2 + c3mn_pkg::SCALE_FRAC;
    localparam int unsigned EXT_W = c3mn_pkg::MASK_BITS + 3 * COEF_BITS;

    localparam logic [1:0] PH_MAC = 2'd0;
    localparam logic [1:0] PH_MUL = 2'd1;
    localparam logic [1:0] PH_SAT = 2'd2;

    logic                      r_busy;
    logic                      r_done;
    logic [1:0]                r_ph;
    logic [1:0]                r_i;
    logic [1:0]                r_j;
    logic [1:0]                r_ch;
    logic [2:0][1:0]           r_csel;
    logic [2:0][1:0]           r_rsel;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PW-1:0]      r_prod;
    logic [2:0][c3mn_pkg::RES_BITS-1:0] r_res;

    logic [c3mn_pkg::MASK_BITS-1:0] w_row;
    logic [EXT_W-1:0]               w_ext;
    logic signed [COEF_BITS-1:0]    w_coef;
    logic [c3mn_pkg::RGB_BITS-1:0]  w_px;
    logic [c3mn_pkg::PIX_BITS-1:0]  w_pix;
    logic signed [TAP_W-1:0]        w_tap;
    logic                           w_neg;
    logic [PW-1:0]                  w_mag;
    logic [PW-1:0]                  w_q;
    logic [c3mn_pkg::RES_BITS-1:0]  w_val;

    // Coefficient and pixel of the current tap, with the mirrored row and column.
    always_comb begin
        case (r_i)
            2'd0:    w_row = i_mask_top;
            2'd1:    w_row = i_mask_mid;
            default: w_row = i_mask_bottom;
        endcase
        w_ext  = {{(3 * COEF_BITS){1'b0}}, w_row};
        w_coef = $signed(w_ext[r_j * COEF_BITS +: COEF_BITS]);
        w_px   = i_win[r_csel[r_j]][r_rsel[r_i]];
        w_pix  = w_px[r_ch * c3mn_pkg::PIX_BITS +: c3mn_pkg::PIX_BITS];
        w_tap  = w_coef * $signed({1'b0, w_pix});
    end

    // Truncate toward zero, then clamp to a byte or saturate to 16 bits.
    always_comb begin
        w_neg = r_prod[PW-1];
        w_mag = w_neg ? PW'(-r_prod) : PW'(r_prod);
        w_q   = w_mag >> SHIFT;
        if (i_clamp) begin
            if (w_neg) begin
                w_val = '0;
            end else if (w_q > PW'(255)) begin
                w_val = 16'd255;
            end else begin
                w_val = 16'(w_q);
            end
        end else begin
            if (w_neg) begin
                w_val = (w_q > PW'(32768)) ? 16'h8000 : 16'(-w_q);
            end else begin
                w_val = (w_q > PW'(32767)) ? 16'h7FFF : 16'(w_q);
            end
        end
    end

    // Sequencer: nine taps per channel, one scaling multiply, one limiting step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= PH_MAC;
            r_i    <= '0;
            r_j    <= '0;
            r_ch   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_ph   <= PH_MAC;
                r_i    <= '0;
                r_j    <= '0;
                r_ch   <= '0;
                r_acc  <= '0;
                r_csel <= i_ctl.csel;
                r_rsel <= i_ctl.rsel;
            end else if (r_busy) begin
                unique case (r_ph)
                    PH_MAC: begin
                        r_acc <= r_acc + ACC_W'(w_tap);
                        if (r_j == 2'd2) begin
                            r_j <= '0;
                            if (r_i == 2'd2) begin
                                r_i  <= '0;
                                r_ph <= PH_MUL;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                    PH_MUL: begin
                        r_prod <= PW'(r_acc) * PW'($signed({1'b0, i_scale}));
                        r_ph   <= PH_SAT;
                    end
                    PH_SAT: begin
                        r_res[r_ch] <= w_val;
                        r_acc       <= '0;
                        r_ph        <= PH_MAC;
                        if (r_ch == 2'd2) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_ch   <= '0;
                        end else begin
                            r_ch <= r_ch + 2'd1;
                        end
                    end
                    default: r_ph <= PH_MAC;
                endcase
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res      = r_res;

endmodule

// File: rtl/conv3x3_mirror_normalized.sv
// Top level of the 3x3 mirror-padded, normalised RGB convolution block.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       i_in_valid / o_in_stall   i_in_item  (pixel or drain mark)
//   out      source     o_out_valid / i_out_stall o_out_item (filtered pixel, position)
//   cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item that yields a result holds the block while one shared multiplier walks 27 taps
// (9 per channel) plus a scaling multiply and a limiting step per channel.
// An item without a result passes through a line-store read and write-back; an ignored
// drain mark is taken with no write-back. Reset is synchronous; the line stores are not
// cleared. The output register lets the next item be accepted while a result waits; a
// stalled result holds the block only when the next result is ready to be loaded.
module conv3x3_mirror_normalized #(
    parameter int unsigned MAX_WIDTH = c3mn_pkg::DEF_MAX_WIDTH,
    parameter int unsigned COEF_BITS = c3mn_pkg::DEF_COEF_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  c3mn_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output c3mn_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [c3mn_pkg::IDX_BITS-1:0]   i_cfg_index,
    input  logic [c3mn_pkg::MASK_BITS-1:0]  i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW = c3mn_pkg::FH_BITS + 1;
    localparam int unsigned LW = 2 * c3mn_pkg::RGB_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;
    localparam logic [1:0] S_SH   = 2'd3;

    // Configuration registers.
    logic [c3mn_pkg::FW_BITS-1:0]   r_fw;
    logic [c3mn_pkg::FH_BITS-1:0]   r_fh;
    logic [c3mn_pkg::MASK_BITS-1:0] r_mask_top;
    logic [c3mn_pkg::MASK_BITS-1:0] r_mask_mid;
    logic [c3mn_pkg::MASK_BITS-1:0] r_mask_bottom;
    logic [c3mn_pkg::NORM_BITS-1:0] r_scale;
    logic                           r_clamp;

    // Control and position state.
    logic [1:0]                    r_state;
    logic                          r_case_a;
    logic [WW-1:0]                 r_in_col;
    logic [HW-1:0]                 r_in_row;
    logic [WW-1:0]                 r_c;
    logic [HW-1:0]                 r_r;
    logic [c3mn_pkg::RGB_BITS-1:0] r_pix;
    c3mn_pkg::t_window             r_win;
    c3mn_pkg::t_mac_ctl            r_ctl;
    logic [c3mn_pkg::COL_BITS-1:0] r_ocol;
    logic [c3mn_pkg::ROW_BITS-1:0] r_orow;
    logic                          r_odone;
    logic                          r_ov;
    c3mn_pkg::t_out_item           r_out;

    logic [WW-1:0]                 w_w;
    logic [HW-1:0]                 w_h;
    logic [WW-1:0]                 w_col1;
    logic [HW-1:0]                 w_row1;
    logic [WW-1:0]                 w_c;
    logic [HW-1:0]                 w_r;
    logic                          w_acc;
    logic                          w_skip;
    logic                          w_start_a;
    logic                          w_start_b;
    logic                          w_out_free;
    logic [HW-1:0]                 w_orow_a;
    logic [HW-1:0]                 w_orow_b;
    logic [CW-1:0]                 w_raddr;
    logic                          w_we;
    logic [LW-1:0]                 w_rdata;
    logic [c3mn_pkg::RGB_BITS-1:0] w_top;
    logic [c3mn_pkg::RGB_BITS-1:0] w_mid;
    c3mn_pkg::t_mac_sts            w_sts;
    logic [2:0][c3mn_pkg::RES_BITS-1:0] w_res;

    // Frame size limited to the supported range.
    always_comb begin
        if (32'(r_fw) > MAX_WIDTH) begin
            w_w = WW'(MAX_WIDTH);
        end else if (r_fw < 11'd2) begin
            w_w = WW'(2);
        end else begin
            w_w = WW'(r_fw);
        end
        if (32'(r_fh) > c3mn_pkg::MAX_HEIGHT) begin
            w_h = HW'(c3mn_pkg::MAX_HEIGHT);
        end else if (r_fh < 13'd2) begin
            w_h = HW'(2);
        end else begin
            w_h = HW'(r_fh);
        end
    end

    // Position of the arriving item after row wrap and frame restart.
    always_comb begin
        if (r_in_col >= w_w) begin
            w_col1 = '0;
            w_row1 = r_in_row + HW'(1);
        end else begin
            w_col1 = r_in_col;
            w_row1 = r_in_row;
        end
        if ((w_row1 > w_h + HW'(1)) || ((w_row1 == w_h + HW'(1)) && (w_col1 != '0))) begin
            w_c = '0;
            w_r = '0;
        end else begin
            w_c = w_col1;
            w_r = w_row1;
        end
    end

    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_skip     = i_in_item.is_drain && (w_r < w_h);
    assign w_start_a  = (r_state == S_IDLE) && w_acc && !w_skip && (w_c == '0)
                        && (w_r >= HW'(2));
    assign w_start_b  = (r_state == S_SH) && (r_c != '0) && (r_r != '0);
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_orow_a   = w_r - HW'(2);
    assign w_orow_b   = r_r - HW'(1);
    assign w_top      = w_rdata[LW-1:c3mn_pkg::RGB_BITS];
    assign w_mid      = w_rdata[c3mn_pkg::RGB_BITS-1:0];
    assign w_raddr    = (r_state == S_IDLE) ? w_c[CW-1:0] : r_c[CW-1:0];
    assign w_we       = (r_state == S_SH);

    // Line stores: upper row in the high half, lower row in the low half.
    c3mn_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_c[CW-1:0]),
        .i_wdata ({w_mid, r_pix}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    c3mn_mac #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (r_ctl),
        .i_win         (r_win),
        .i_mask_top    (r_mask_top),
        .i_mask_mid    (r_mask_mid),
        .i_mask_bottom (r_mask_bottom),
        .i_scale       (r_scale),
        .i_clamp       (r_clamp),
        .o_sts         (w_sts),
        .o_res         (w_res)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw          <= c3mn_pkg::RST_FRAME_WIDTH;
            r_fh          <= c3mn_pkg::RST_FRAME_HEIGHT;
            r_mask_top    <= c3mn_pkg::RST_MASK_TOP;
            r_mask_mid    <= c3mn_pkg::RST_MASK_MID;
            r_mask_bottom <= c3mn_pkg::RST_MASK_BOTTOM;
            r_scale       <= c3mn_pkg::RST_NORM_SCALE;
            r_clamp       <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                c3mn_pkg::CFG_FRAME_WIDTH:  r_fw <= i_cfg_data[c3mn_pkg::FW_BITS-1:0];
                c3mn_pkg::CFG_FRAME_HEIGHT: r_fh <= i_cfg_data[c3mn_pkg::FH_BITS-1:0];
                c3mn_pkg::CFG_MASK_TOP:     r_mask_top <= i_cfg_data;
                c3mn_pkg::CFG_MASK_MID:     r_mask_mid <= i_cfg_data;
                c3mn_pkg::CFG_MASK_BOTTOM:  r_mask_bottom <= i_cfg_data;
                c3mn_pkg::CFG_NORM_SCALE:   r_scale <= i_cfg_data[c3mn_pkg::NORM_BITS-1:0];
                c3mn_pkg::CFG_CLAMP:        r_clamp <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Item sequencer: window flush, line-store update, filtering and result hand-off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_case_a  <= 1'b0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_win     <= '0;
            r_ctl     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_ctl.start <= w_start_a || w_start_b;
            // The output register is loaded from the filter or emptied when its item is taken.
            if ((r_state == S_OUT) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_in_col <= w_c;
                        r_in_row <= w_r;
                        r_c      <= w_c;
                        r_r      <= w_r;
                        r_pix    <= (w_r < w_h) ? {i_in_item.pix_blue, i_in_item.pix_green,
                                                   i_in_item.pix_red} : '0;
                        if (w_skip) begin
                            r_state <= S_IDLE;
                        end else if (w_start_a) begin
                            // Last pixel of the row two rows back, from the old window.
                            r_case_a    <= 1'b1;
                            r_ctl.csel  <= {2'd1, 2'd2, 2'd1};
                            r_ctl.rsel  <= {(w_orow_a == w_h - HW'(1)) ? 2'd0 : 2'd2, 2'd1,
                                            (w_orow_a == '0) ? 2'd2 : 2'd0};
                            r_ocol      <= c3mn_pkg::COL_BITS'(w_w - WW'(1));
                            r_orow      <= c3mn_pkg::ROW_BITS'(w_orow_a);
                            r_odone     <= (w_orow_a == w_h - HW'(1));
                            r_state     <= S_MAC;
                        end else begin
                            r_state <= S_SH;
                        end
                    end
                end
                S_MAC: begin
                    if (w_sts.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out.res_red         <= w_res[0];
                        r_out.res_green       <= w_res[1];
                        r_out.res_blue        <= w_res[2];
                        r_out.res_col         <= r_ocol;
                        r_out.res_row         <= r_orow;
                        r_out.frame_done      <= r_odone;
                        if (!r_case_a) begin
                            r_in_col <= r_c + WW'(1);
                            r_state  <= S_IDLE;
                        end else if (r_r == w_h + HW'(1)) begin
                            r_in_col <= '0;
                            r_in_row <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_SH;
                        end
                    end
                end
                S_SH: begin
                    // Shift the window and push in the new column.
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= {r_pix, w_mid, w_top};
                    if (w_start_b) begin
                        r_case_a    <= 1'b0;
                        r_ctl.csel  <= {2'd2, 2'd1, (r_c == WW'(1)) ? 2'd2 : 2'd0};
                        r_ctl.rsel  <= {(w_orow_b == w_h - HW'(1)) ? 2'd0 : 2'd2, 2'd1,
                                        (w_orow_b == '0) ? 2'd2 : 2'd0};
                        r_ocol      <= c3mn_pkg::COL_BITS'(r_c - WW'(1));
                        r_orow      <= c3mn_pkg::ROW_BITS'(w_orow_b);
                        r_odone     <= 1'b0;
                        r_state     <= S_MAC;
                    end else begin
                        r_in_col <= r_c + WW'(1);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// File: rtl/c3mn_checker.sv
// Port-level checker for the convolution block and its bind to the top level.
module c3mn_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input c3mn_pkg::t_in_item              i_in_item,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input c3mn_pkg::t_out_item             o_out_item,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [c3mn_pkg::IDX_BITS-1:0]   i_cfg_index,
    input logic [c3mn_pkg::MASK_BITS-1:0]  i_cfg_data
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // The frame ends on a row other than the first, since frames have two rows or more.
    a_done_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_done |-> o_out_item.res_row != '0)
        else $error("frame end reported on row zero");

    // Filtering runs through the multiply-accumulate sequence, so no result appears right after an item is taken.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && !o_in_stall))
        else $error("result appeared one cycle after an item");

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind conv3x3_mirror_normalized c3mn_checker u_c3mn_checker (.*);

// File: tb/tb_conv3x3_mirror_normalized.sv
// Self-checking testbench for the 3x3 mirror-padded normalised RGB convolution block.
`timescale 1ns / 1ps

module tb_conv3x3_mirror_normalized;

    // Ways in which the two sides idle during a phase of the run.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 580;
    localparam int PHASE_ITEMS    = 145;

    // Predicts the filtered pixels and checks the block's results against them in order.
    class conv_scoreboard;
        logic [c3mn_pkg::FW_BITS-1:0]   width_reg;
        logic [c3mn_pkg::FH_BITS-1:0]   height_reg;
        logic [c3mn_pkg::MASK_BITS-1:0] mask_reg [3];
        logic [c3mn_pkg::NORM_BITS-1:0] norm_reg;
        logic                           clamp_reg;
        logic [c3mn_pkg::RGB_BITS-1:0]  upper_line [c3mn_pkg::DEF_MAX_WIDTH];
        logic [c3mn_pkg::RGB_BITS-1:0]  lower_line [c3mn_pkg::DEF_MAX_WIDTH];
        logic [c3mn_pkg::RGB_BITS-1:0]  win [3][3];
        int unsigned                    col_pos;
        int unsigned                    row_pos;
        c3mn_pkg::t_out_item            pending [$];
        int                             errors;

        function new();
            width_reg   = c3mn_pkg::RST_FRAME_WIDTH;
            height_reg  = c3mn_pkg::RST_FRAME_HEIGHT;
            mask_reg[0] = c3mn_pkg::RST_MASK_TOP;
            mask_reg[1] = c3mn_pkg::RST_MASK_MID;
            mask_reg[2] = c3mn_pkg::RST_MASK_BOTTOM;
            norm_reg    = c3mn_pkg::RST_NORM_SCALE;
            clamp_reg   = 1'b1;
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [c3mn_pkg::IDX_BITS-1:0] idx,
                                logic [c3mn_pkg::MASK_BITS-1:0] data);
            case (idx)
                c3mn_pkg::CFG_FRAME_WIDTH: begin
                    width_reg = data[c3mn_pkg::FW_BITS-1:0];
                end
                c3mn_pkg::CFG_FRAME_HEIGHT: begin
                    height_reg = data[c3mn_pkg::FH_BITS-1:0];
                end
                c3mn_pkg::CFG_MASK_TOP: begin
                    mask_reg[0] = data;
                end
                c3mn_pkg::CFG_MASK_MID: begin
                    mask_reg[1] = data;
                end
                c3mn_pkg::CFG_MASK_BOTTOM: begin
                    mask_reg[2] = data;
                end
                c3mn_pkg::CFG_NORM_SCALE: begin
                    norm_reg = data[c3mn_pkg::NORM_BITS-1:0];
                end
                c3mn_pkg::CFG_CLAMP: begin
                    clamp_reg = data[0];
                end
                default: begin
                end
            endcase
        endfunction

        // One filtered pixel from the window, with mirrored rows and the given columns.
        function c3mn_pkg::t_out_item filter(int lc, int cc, int rc, int orow, int ocol, int h,
                                             bit last);
            int        rsel [3];
            int        csel [3];
            longint    acc;
            longint    prod;
            longint    val;
            longint    mag;
            longint    q;
            logic signed [15:0] coef;
            logic [15:0] res [3];
            c3mn_pkg::t_out_item r;
            rsel[0] = (orow == 0) ? 2 : 0;
            rsel[1] = 1;
            rsel[2] = (orow == h - 1) ? 0 : 2;
            csel[0] = lc;
            csel[1] = cc;
            csel[2] = rc;
            for (int ch = 0; ch < 3; ch++) begin
                acc = 0;
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        coef = mask_reg[i][j*16 +: 16];
                        acc += longint'(coef) * longint'(win[csel[j]][rsel[i]][ch*8 +: 8]);
                    end
                end
                prod = acc * longint'({40'd0, norm_reg});
                mag  = (prod < 0) ? -prod : prod;
                q    = mag >>> 24;
                if (q > 65536) q = 65536;
                val = (prod < 0) ? -q : q;
                if (clamp_reg) begin
                    if (val < 0) val = 0;
                    if (val > 255) val = 255;
                end else begin
                    if (val < -32768) val = -32768;
                    if (val > 32767) val = 32767;
                end
                res[ch] = val[15:0];
            end
            r.res_red    = res[0];
            r.res_green  = res[1];
            r.res_blue   = res[2];
            r.res_col    = ocol[c3mn_pkg::COL_BITS-1:0];
            r.res_row    = orow[c3mn_pkg::ROW_BITS-1:0];
            r.frame_done = last;
            return r;
        endfunction

        // Advances the raster position for one accepted item and queues its result if it yields one.
        function void note_input(c3mn_pkg::t_in_item it);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            logic [c3mn_pkg::RGB_BITS-1:0] pix;
            logic [c3mn_pkg::RGB_BITS-1:0] top;
            logic [c3mn_pkg::RGB_BITS-1:0] mid;
            w = width_reg;
            h = height_reg;
            if (w < 2) w = 2;
            if (w > c3mn_pkg::DEF_MAX_WIDTH) w = c3mn_pkg::DEF_MAX_WIDTH;
            if (h < 2) h = 2;
            if (h > c3mn_pkg::MAX_HEIGHT) h = c3mn_pkg::MAX_HEIGHT;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos > h + 1 || (row_pos == h + 1 && col_pos != 0)) begin
                row_pos = 0;
                col_pos = 0;
            end
            c = col_pos;
            r = row_pos;
            // A drain mark while pixels are still due is ignored.
            if (it.is_drain && r < h) return;
            pix = (r < h) ? {it.pix_blue, it.pix_green, it.pix_red} : '0;
            if (c == 0) begin
                if (r >= 2) pending.push_back(filter(1, 2, 1, r - 2, w - 1, h, r - 2 == h - 1));
                if (r == h + 1) begin
                    row_pos = 0;
                    col_pos = 0;
                    return;
                end
            end
            top = upper_line[c];
            mid = lower_line[c];
            upper_line[c] = mid;
            lower_line[c] = pix;
            win[0] = win[1];
            win[1] = win[2];
            win[2][0] = top;
            win[2][1] = mid;
            win[2][2] = pix;
            if (c >= 1 && r >= 1) pending.push_back(filter((c == 1) ? 2 : 0, 1, 2, r - 1, c - 1,
                                                           h, 1'b0));
            col_pos = c + 1;
        endfunction

        function void check_result(c3mn_pkg::t_out_item got);
            c3mn_pkg::t_out_item exp_item;
            if (pending.size() == 0) begin
                $error("unexpected result: col %0d row %0d", got.res_col, got.res_row);
                errors++;
                return;
            end
            exp_item = pending.pop_front();
            if (got.res_red !== exp_item.res_red) begin
                $error("res_red: expected %0d, got %0d", exp_item.res_red, got.res_red);
                errors++;
            end
            if (got.res_green !== exp_item.res_green) begin
                $error("res_green: expected %0d, got %0d", exp_item.res_green, got.res_green);
                errors++;
            end
            if (got.res_blue !== exp_item.res_blue) begin
                $error("res_blue: expected %0d, got %0d", exp_item.res_blue, got.res_blue);
                errors++;
            end
            if (got.res_col !== exp_item.res_col) begin
                $error("res_col: expected %0d, got %0d", exp_item.res_col, got.res_col);
                errors++;
            end
            if (got.res_row !== exp_item.res_row) begin
                $error("res_row: expected %0d, got %0d", exp_item.res_row, got.res_row);
                errors++;
            end
            if (got.frame_done !== exp_item.frame_done) begin
                $error("frame_done: expected %0d, got %0d", exp_item.frame_done,
                       got.frame_done);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    c3mn_pkg::t_in_item             i_in_item;
    logic                           o_out_valid;
    logic                           i_out_stall;
    c3mn_pkg::t_out_item            o_out_item;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [c3mn_pkg::IDX_BITS-1:0]  i_cfg_index;
    logic [c3mn_pkg::MASK_BITS-1:0] i_cfg_data;

    conv_scoreboard sb;
    t_idle_mode     idle_mode;
    bit             hold_req;
    int             hold_left;
    int             quiet_cycles;
    int             pixel_count;

    conv3x3_mirror_normalized dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 2 ns period.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: random stalls by phase, or one long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else if (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH) begin
            i_out_stall = ($urandom_range(0, 99) < 83);
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Results are checked as they are accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** conv3x3_mirror_normalized: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(logic [c3mn_pkg::IDX_BITS-1:0] idx,
                             logic [c3mn_pkg::MASK_BITS-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_item(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                             logic drain);
        c3mn_pkg::t_in_item it;
        it.pix_red   = red;
        it.pix_green = green;
        it.pix_blue  = blue;
        it.is_drain  = drain;
        if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(0, 99) < 83) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sender pauses until every result is in, then lets the block settle.
    task automatic settle();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One whole frame with its drain items; stray marks are mixed in as noise.
    task automatic run_frame(int w, int h, bit noise);
        for (int n = 0; n < w * h; n++) begin
            if (noise && $urandom_range(0, 99) < 8)
                send_item(rand_sample(), rand_sample(), rand_sample(), 1'b1);
            send_item(rand_sample(), rand_sample(), rand_sample(), 1'b0);
        end
        for (int n = 0; n <= w; n++)
            send_item(rand_sample(), rand_sample(), rand_sample(),
                      !(noise && $urandom_range(0, 99) < 10));
        pixel_count += w * h + w + 1;
        settle();
    endtask

    function automatic logic [c3mn_pkg::MASK_BITS-1:0] rand_mask();
        logic [c3mn_pkg::MASK_BITS-1:0] m;
        if ($urandom_range(0, 3) == 0) begin
            m = {16'($urandom), 32'($urandom)};
        end else begin
            for (int k = 0; k < 3; k++) m[k*16 +: 16] = 16'($urandom_range(0, 1023) - 512);
        end
        return m;
    endfunction

    // New random settings for every register; returns the frame size in use.
    task automatic random_setup(output int w, output int h);
        logic [c3mn_pkg::FW_BITS-1:0] wr;
        logic [c3mn_pkg::FH_BITS-1:0] hr;
        wr = 11'($urandom_range(0, 8));
        hr = 13'($urandom_range(0, 6));
        write_reg(c3mn_pkg::CFG_FRAME_WIDTH, c3mn_pkg::MASK_BITS'(wr));
        write_reg(c3mn_pkg::CFG_FRAME_HEIGHT, c3mn_pkg::MASK_BITS'(hr));
        write_reg(c3mn_pkg::CFG_MASK_TOP, rand_mask());
        write_reg(c3mn_pkg::CFG_MASK_MID, rand_mask());
        write_reg(c3mn_pkg::CFG_MASK_BOTTOM, rand_mask());
        case ($urandom_range(0, 5))
            0: write_reg(c3mn_pkg::CFG_NORM_SCALE, 48'd0);
            1: write_reg(c3mn_pkg::CFG_NORM_SCALE, 48'hFF_FFFF);
            2: write_reg(c3mn_pkg::CFG_NORM_SCALE, 48'd65536);
            default: write_reg(c3mn_pkg::CFG_NORM_SCALE,
                               48'($urandom_range(0, 24'hFF_FFFF)));
        endcase
        write_reg(c3mn_pkg::CFG_CLAMP, 48'($urandom_range(0, 1)));
        w = (wr < 2) ? 2 : wr;
        h = (hr < 2) ? 2 : hr;
    endtask

    initial begin
        int w;
        int h;
        sb           = new();
        idle_mode    = IDLE_NONE;
        hold_req     = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        pixel_count  = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = c3mn_pkg::CFG_FRAME_WIDTH;
        i_cfg_data   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extreme coefficients and scale, signed saturation, black and white pixels.
        write_reg(c3mn_pkg::CFG_FRAME_WIDTH, 48'd3);
        write_reg(c3mn_pkg::CFG_FRAME_HEIGHT, 48'd3);
        write_reg(c3mn_pkg::CFG_MASK_TOP, 48'h8000_8000_8000);
        write_reg(c3mn_pkg::CFG_MASK_MID, 48'h7FFF_7FFF_7FFF);
        write_reg(c3mn_pkg::CFG_MASK_BOTTOM, 48'h0100_FFFF_0001);
        write_reg(c3mn_pkg::CFG_NORM_SCALE, 48'hFF_FFFF);
        write_reg(c3mn_pkg::CFG_CLAMP, 48'd0);
        for (int n = 0; n < 9; n++) begin
            if (n == 4) send_item(8'd255, 8'd255, 8'd255, 1'b1);
            send_item((n % 2) ? 8'd255 : 8'd0, (n % 3) ? 8'd0 : 8'd255, 8'd255, 1'b0);
        end
        send_item(8'd255, 8'd0, 8'd255, 1'b0);
        for (int n = 0; n < 3; n++) send_item(8'd0, 8'd0, 8'd0, 1'b1);
        settle();

        // Widths and heights below the minimum, zero scale, byte clamping.
        write_reg(c3mn_pkg::CFG_FRAME_WIDTH, 48'd1);
        write_reg(c3mn_pkg::CFG_FRAME_HEIGHT, 48'd0);
        write_reg(c3mn_pkg::CFG_NORM_SCALE, 48'd0);
        write_reg(c3mn_pkg::CFG_CLAMP, 48'd1);
        run_frame(2, 2, 1'b0);
        write_reg(c3mn_pkg::CFG_FRAME_WIDTH, 48'd0);
        write_reg(c3mn_pkg::CFG_FRAME_HEIGHT, 48'd1);
        write_reg(c3mn_pkg::CFG_NORM_SCALE, 48'd65536);
        run_frame(2, 2, 1'b0);

        // Long hold-off on the result side while the sender keeps offering pixels.
        write_reg(c3mn_pkg::CFG_FRAME_WIDTH, 48'd8);
        write_reg(c3mn_pkg::CFG_FRAME_HEIGHT, 48'd4);
        hold_req = 1'b1;
        run_frame(8, 4, 1'b0);

        // Random frames through each idling phase.
        pixel_count = 0;
        while (pixel_count < RANDOM_ITEMS) begin
            idle_mode = t_idle_mode'(pixel_count / PHASE_ITEMS);
            random_setup(w, h);
            run_frame(w, h, 1'b1);
        end
        idle_mode = IDLE_NONE;

        if (sb.errors == 0) begin
            $display("** conv3x3_mirror_normalized: PASSED **");
        end else begin
            $display("** conv3x3_mirror_normalized: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/c3mn_pkg.sv
rtl/c3mn_ram.sv
rtl/c3mn_mac.sv
rtl/conv3x3_mirror_normalized.sv
rtl/c3mn_checker.sv
tb/tb_conv3x3_mirror_normalized.sv
